>>> rtl/core/ramped_setpoint_pi_position_drive_core_assert.svh
// Assertion macros shared by the position drive core RTL.
`ifndef RAMPED_SETPOINT_PI_POSITION_DRIVE_CORE_ASSERT_SVH
`define RAMPED_SETPOINT_PI_POSITION_DRIVE_CORE_ASSERT_SVH

// Same-cycle implication, disabled during reset.
`define RSPD_ASSERT_IMPL(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled during reset.
`define RSPD_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

>>> rtl/core/rspd_pkg.sv
// Shared types and constants for the ramped setpoint PI position drive.
`timescale 1ns / 1ps
package rspd_pkg;

    localparam int ANGLE_WIDTH_DEF = 16;
    localparam int CFG_IDX_W       = 3;
    localparam int CFG_MIN_W       = 24;
    localparam int DRIVE_W         = 8;
    localparam int DRIVE_LIMIT     = 100;
    localparam int COUNT_W         = 8;

    localparam logic [COUNT_W-1:0] COUNT_MAX = 8'hFF;

    localparam logic               DIRECTION_RST = 1'b1;
    localparam logic [15:0]        PROP_GAIN_RST = 16'd7578;

    localparam logic [CFG_IDX_W-1:0] CFG_DIRECTION     = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_TARGET_ANGLE  = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_STEP_INTERVAL = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_STEP_SIZE     = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_PROP_GAIN     = 3'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_INTEG_GAIN    = 3'd5;

    typedef struct packed {
        logic                direction;
        logic [COUNT_W-1:0]  step_interval;
        logic [7:0]          step_size;
        logic [15:0]         prop_gain;
        logic [23:0]         integ_gain;
    } t_cfg;

endpackage

>>> rtl/core/rspd_cfg.sv
// Configuration register file of the position drive.
`timescale 1ns / 1ps
module rspd_cfg #(
    parameter int ANGLE_WIDTH = rspd_pkg::ANGLE_WIDTH_DEF
) (
    input  logic                                   i_clk,
    input  logic                                   i_rst_n,
    input  logic                                   i_cfg_valid,
    input  logic [rspd_pkg::CFG_IDX_W-1:0]         i_cfg_index,
    input  logic [((ANGLE_WIDTH > rspd_pkg::CFG_MIN_W) ?
                   ANGLE_WIDTH : rspd_pkg::CFG_MIN_W)-1:0] i_cfg_data,
    output rspd_pkg::t_cfg                         o_cfg,
    output logic signed [ANGLE_WIDTH-1:0]          o_target_angle
);
    import rspd_pkg::*;

    t_cfg                          r_cfg;
    logic signed [ANGLE_WIDTH-1:0] r_target_angle;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.direction     <= DIRECTION_RST;
            r_cfg.step_interval <= '0;
            r_cfg.step_size     <= '0;
            r_cfg.prop_gain     <= PROP_GAIN_RST;
            r_cfg.integ_gain    <= '0;
            r_target_angle      <= '0;
        end else if (i_cfg_valid) begin
            unique case (i_cfg_index)
                CFG_DIRECTION:     r_cfg.direction     <= i_cfg_data[0];
                CFG_TARGET_ANGLE:  r_target_angle      <= i_cfg_data[ANGLE_WIDTH-1:0];
                CFG_STEP_INTERVAL: r_cfg.step_interval <= i_cfg_data[COUNT_W-1:0];
                CFG_STEP_SIZE:     r_cfg.step_size     <= i_cfg_data[7:0];
                CFG_PROP_GAIN:     r_cfg.prop_gain     <= i_cfg_data[15:0];
                CFG_INTEG_GAIN:    r_cfg.integ_gain    <= i_cfg_data[23:0];
                default: ;
            endcase
        end
    end

    assign o_cfg          = r_cfg;
    assign o_target_angle = r_target_angle;

endmodule

>>> rtl/core/rspd_ramp.sv
// Setpoint ramp, tick counter, held error and saturating integral.
`timescale 1ns / 1ps
`include "ramped_setpoint_pi_position_drive_core_assert.svh"
module rspd_ramp #(
    parameter int ANGLE_WIDTH = rspd_pkg::ANGLE_WIDTH_DEF,
    parameter int SP_W        = ANGLE_WIDTH + 1
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_adv,
    input  logic                           i_in_valid,
    input  logic signed [ANGLE_WIDTH-1:0]  i_measured_angle,
    input  logic                           i_restart,
    input  rspd_pkg::t_cfg                 i_cfg,
    input  logic signed [ANGLE_WIDTH-1:0]  i_target_angle,
    output logic                           o_valid,
    output logic signed [SP_W:0]           o_held_error,
    output logic signed [31:0]             o_error_sum,
    output logic signed [SP_W-1:0]         o_setpoint
);
    import rspd_pkg::*;

    localparam int ERR_W  = SP_W + 1;
    localparam int SUMX_W = ((ERR_W > 32) ? ERR_W : 32) + 1;

    logic                      r_valid;
    logic signed [SP_W-1:0]    r_setpoint;
    logic [COUNT_W-1:0]        r_tick_count;
    logic signed [ERR_W-1:0]   r_held_error;
    logic signed [31:0]        r_error_sum;

    logic signed [SP_W-1:0]    n_setpoint;
    logic [COUNT_W-1:0]        n_tick_count;
    logic signed [ERR_W-1:0]   n_held_error;
    logic signed [31:0]        n_error_sum;

    logic                      w_acc;
    logic signed [SP_W-1:0]    w_meas_x;
    logic signed [SP_W-1:0]    w_tgt_x;
    logic signed [SP_W-1:0]    w_step_x;
    logic signed [SP_W-1:0]    w_sp0;
    logic [COUNT_W-1:0]        w_tick1;
    logic                      w_active;
    logic                      w_step_due;
    logic signed [SUMX_W-1:0]  w_sum_x;

    assign w_acc    = i_in_valid & i_adv;
    assign w_meas_x = SP_W'(i_measured_angle);
    assign w_tgt_x  = SP_W'(i_target_angle);
    assign w_step_x = signed'({{(SP_W-8){1'b0}}, i_cfg.step_size});
    assign w_sp0    = i_restart ? w_meas_x : r_setpoint;
    assign w_tick1  = (r_tick_count == COUNT_MAX) ? r_tick_count
                                                  : r_tick_count + COUNT_W'(1);
    assign w_active = i_cfg.direction ? (w_sp0 >= w_tgt_x) : (w_sp0 <= w_tgt_x);
    assign w_step_due = w_tick1 >= i_cfg.step_interval;

    always_comb begin
        n_setpoint   = w_tgt_x;
        n_tick_count = w_tick1;
        n_held_error = r_held_error;
        if (w_active) begin
            n_held_error = ERR_W'(w_sp0) - ERR_W'(i_measured_angle);
            n_setpoint   = w_sp0;
            if (w_step_due) begin
                n_setpoint   = i_cfg.direction ? (w_sp0 - w_step_x) : (w_sp0 + w_step_x);
                n_tick_count = '0;
            end
        end
        w_sum_x = SUMX_W'(r_error_sum) + SUMX_W'(n_held_error);
        if ((w_sum_x[SUMX_W-1:31] == '0) || (w_sum_x[SUMX_W-1:31] == '1)) begin
            n_error_sum = w_sum_x[31:0];
        end else if (w_sum_x[SUMX_W-1]) begin
            n_error_sum = 32'sh8000_0000;
        end else begin
            n_error_sum = 32'sh7FFF_FFFF;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid      <= 1'b0;
            r_setpoint   <= '0;
            r_tick_count <= '0;
            r_held_error <= '0;
            r_error_sum  <= '0;
        end else begin
            if (i_adv) begin
                r_valid <= i_in_valid;
            end
            if (w_acc) begin
                r_setpoint   <= n_setpoint;
                r_tick_count <= n_tick_count;
                r_held_error <= n_held_error;
                r_error_sum  <= n_error_sum;
            end
        end
    end

    assign o_valid      = r_valid;
    assign o_held_error = r_held_error;
    assign o_error_sum  = r_error_sum;
    assign o_setpoint   = r_setpoint;

    `RSPD_ASSERT_NEXT(a_state_idle_hold, !w_acc, $stable(r_setpoint) && $stable(r_tick_count) && $stable(r_error_sum), "ramp state changed without a transfer")
    `RSPD_ASSERT_NEXT(a_stage_hold, r_valid && !i_adv, r_valid && $stable(r_held_error), "ramp stage lost its item while stalled")

endmodule

>>> rtl/core/rspd_drive.sv
// PI product stage and rounding/clamp stage of the drive output.
`timescale 1ns / 1ps
`include "ramped_setpoint_pi_position_drive_core_assert.svh"
module rspd_drive #(
    parameter int SP_W = rspd_pkg::ANGLE_WIDTH_DEF + 1
) (
    input  logic                                  i_clk,
    input  logic                                  i_rst_n,
    input  logic                                  i_adv,
    input  logic                                  i_valid,
    input  logic signed [SP_W:0]                  i_held_error,
    input  logic signed [31:0]                    i_error_sum,
    input  logic signed [SP_W-1:0]                i_setpoint,
    input  logic [15:0]                           i_prop_gain,
    input  logic [23:0]                           i_integ_gain,
    output logic                                  o_valid,
    output logic signed [rspd_pkg::DRIVE_W-1:0]   o_drive,
    output logic signed [SP_W-1:0]                o_setpoint
);
    import rspd_pkg::*;

    localparam int ERR_W = SP_W + 1;
    localparam int P_W   = ERR_W + 17;
    localparam int I_W   = 32 + 25;
    localparam int ACC_W = (((P_W + 12) > I_W) ? (P_W + 12) : I_W) + 1;
    localparam int Q_W   = ACC_W - 24;
    localparam logic signed [Q_W-1:0] Q_HI = Q_W'(DRIVE_LIMIT);
    localparam logic signed [Q_W-1:0] Q_LO = -Q_HI;

    logic                        r_vb;
    logic signed [P_W-1:0]       r_pterm;
    logic signed [I_W-1:0]       r_iterm;
    logic signed [SP_W-1:0]      r_sp_b;
    logic                        r_vc;
    logic signed [DRIVE_W-1:0]   r_drive;
    logic signed [SP_W-1:0]      r_sp_c;

    logic signed [P_W-1:0]       n_pterm;
    logic signed [I_W-1:0]       n_iterm;
    logic signed [DRIVE_W-1:0]   n_drive;

    logic signed [ACC_W-1:0]     w_acc;
    logic signed [Q_W-1:0]       w_q;
    logic signed [Q_W-1:0]       w_qt;

    assign n_pterm = P_W'(signed'({1'b0, i_prop_gain})) * P_W'(i_held_error);
    assign n_iterm = I_W'(signed'({1'b0, i_integ_gain})) * I_W'(i_error_sum);

    // Q24 sum, divide by 2^24 truncating toward zero
    assign w_acc = (ACC_W'(r_pterm) <<< 12) + ACC_W'(r_iterm);
    assign w_q   = w_acc[ACC_W-1:24];
    assign w_qt  = w_q + Q_W'(w_acc[ACC_W-1] && (|w_acc[23:0]));

    always_comb begin
        if (w_qt > Q_HI) begin
            n_drive = DRIVE_W'(Q_HI);
        end else if (w_qt < Q_LO) begin
            n_drive = DRIVE_W'(Q_LO);
        end else begin
            n_drive = w_qt[DRIVE_W-1:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vb <= 1'b0;
            r_vc <= 1'b0;
        end else if (i_adv) begin
            r_vb <= i_valid;
            r_vc <= r_vb;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_adv) begin
            r_pterm <= n_pterm;
            r_iterm <= n_iterm;
            r_sp_b  <= i_setpoint;
            r_drive <= n_drive;
            r_sp_c  <= r_sp_b;
        end
    end

    assign o_valid    = r_vc;
    assign o_drive    = r_drive;
    assign o_setpoint = r_sp_c;

    `RSPD_ASSERT_IMPL(a_drive_clamped, r_vc, (r_drive <= 8'sd100) && (r_drive >= -8'sd100), "drive outside clamp range")
    `RSPD_ASSERT_NEXT(a_stage_b_moves, i_adv && r_vb, r_vc, "product stage item did not reach output")

endmodule

>>> rtl/core/ramped_setpoint_pi_position_drive_core.sv
// Top level of the ramped setpoint PI position drive.
//
//  channel | direction | handshake                   | payload
//  --------+-----------+-----------------------------+----------------------------------
//  in      | sink      | i_in_valid / o_in_stall     | i_measured_angle, i_restart
//  out     | source    | o_out_valid / i_out_stall   | o_drive, o_setpoint_now
//  cfg     | sink      | i_cfg_valid / o_cfg_ready   | i_cfg_index, i_cfg_data
//
// One tick per cycle unless stalled; ticks pass the ramp, product and output registers.
// Stages: ramp/integral state, PI products, Q24 sum with truncation and clamp.
// The tick recurrence of the ramp and integral closes in the first stage.
// Synchronous active-low reset; config registers return to their defaults.
// A stalled output freezes all stages; o_in_stall follows it.
`timescale 1ns / 1ps
module ramped_setpoint_pi_position_drive_core #(
    parameter int ANGLE_WIDTH = rspd_pkg::ANGLE_WIDTH_DEF
) (
    input  logic                                  i_clk,
    input  logic                                  i_rst_n,
    input  logic                                  i_in_valid,
    output logic                                  o_in_stall,
    input  logic signed [ANGLE_WIDTH-1:0]         i_measured_angle,
    input  logic                                  i_restart,
    output logic                                  o_out_valid,
    input  logic                                  i_out_stall,
    output logic signed [rspd_pkg::DRIVE_W-1:0]   o_drive,
    output logic signed [ANGLE_WIDTH:0]           o_setpoint_now,
    input  logic                                  i_cfg_valid,
    output logic                                  o_cfg_ready,
    input  logic [rspd_pkg::CFG_IDX_W-1:0]        i_cfg_index,
    input  logic [((ANGLE_WIDTH > rspd_pkg::CFG_MIN_W) ?
                   ANGLE_WIDTH : rspd_pkg::CFG_MIN_W)-1:0] i_cfg_data
);
    import rspd_pkg::*;

    // setpoint can run one step past the target
    localparam int SP_W = (ANGLE_WIDTH >= 9) ? (ANGLE_WIDTH + 1) : 10;

    t_cfg                          w_cfg;
    logic signed [ANGLE_WIDTH-1:0] w_target_angle;
    logic                          w_adv;
    logic                          w_a_valid;
    logic signed [SP_W:0]          w_held_error;
    logic signed [31:0]            w_error_sum;
    logic signed [SP_W-1:0]        w_a_setpoint;
    logic signed [SP_W-1:0]        w_c_setpoint;

    assign w_adv       = !(o_out_valid && i_out_stall);
    assign o_in_stall  = !w_adv;
    assign o_cfg_ready = 1'b1;

    rspd_cfg #(
        .ANGLE_WIDTH (ANGLE_WIDTH)
    ) u_cfg (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cfg_valid    (i_cfg_valid),
        .i_cfg_index    (i_cfg_index),
        .i_cfg_data     (i_cfg_data),
        .o_cfg          (w_cfg),
        .o_target_angle (w_target_angle)
    );

    rspd_ramp #(
        .ANGLE_WIDTH (ANGLE_WIDTH),
        .SP_W        (SP_W)
    ) u_ramp (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_adv            (w_adv),
        .i_in_valid       (i_in_valid),
        .i_measured_angle (i_measured_angle),
        .i_restart        (i_restart),
        .i_cfg            (w_cfg),
        .i_target_angle   (w_target_angle),
        .o_valid          (w_a_valid),
        .o_held_error     (w_held_error),
        .o_error_sum      (w_error_sum),
        .o_setpoint       (w_a_setpoint)
    );

    rspd_drive #(
        .SP_W (SP_W)
    ) u_drive (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_adv        (w_adv),
        .i_valid      (w_a_valid),
        .i_held_error (w_held_error),
        .i_error_sum  (w_error_sum),
        .i_setpoint   (w_a_setpoint),
        .i_prop_gain  (w_cfg.prop_gain),
        .i_integ_gain (w_cfg.integ_gain),
        .o_valid      (o_out_valid),
        .o_drive      (o_drive),
        .o_setpoint   (w_c_setpoint)
    );

    assign o_setpoint_now = w_c_setpoint[ANGLE_WIDTH:0];

endmodule

>>> bench/tb_ramped_setpoint_pi_position_drive_core.sv
// Self-checking testbench for the ramped setpoint PI position drive core.
`timescale 1ns / 1ps
module tb_ramped_setpoint_pi_position_drive_core;
    import rspd_pkg::*;

    localparam int     CFG_DATA_W   = CFG_MIN_W;
    localparam int     RAND_TICKS   = 800;
    localparam int     HOLD_CYCLES  = 60;
    localparam int     CYCLE_LIMIT  = 1000000;
    localparam int     MAX_REPORTS  = 100;
    localparam longint SUM_MAX      = 64'sd2147483647;
    localparam longint SUM_MIN      = -64'sd2147483648;
    localparam longint Q24_ONE      = 64'sd16777216;
    localparam longint Q12_TO_Q24   = 64'sd4096;

    localparam logic signed [15:0] ANGLE_MAX = 16'sh7FFF;
    localparam logic signed [15:0] ANGLE_MIN = 16'sh8000;

    localparam logic [CFG_IDX_W-1:0] CFG_IDX_SPARE0 = 3'd6;
    localparam logic [CFG_IDX_W-1:0] CFG_IDX_SPARE1 = 3'd7;

    typedef struct packed {
        logic signed [DRIVE_W-1:0] drive;
        logic signed [16:0]        setpoint;
    } t_drive_result;

    typedef enum logic [0:0] {ROW_TICK, ROW_CFG} t_row_kind;

    typedef struct packed {
        t_row_kind             kind;
        logic [CFG_IDX_W-1:0]  idx;
        logic [CFG_DATA_W-1:0] data;
        logic signed [15:0]    meas;
        logic                  rbit;
        int                    reps;
        bit                    typed;
        t_drive_result         want;
    } t_stim_row;

    logic                         i_clk            = 1'b0;
    logic                         i_rst_n          = 1'b0;
    logic                         i_in_valid       = 1'b0;
    logic signed [15:0]           i_measured_angle = '0;
    logic                         i_restart        = 1'b0;
    logic                         i_out_stall      = 1'b0;
    logic                         i_cfg_valid      = 1'b0;
    logic [CFG_IDX_W-1:0]         i_cfg_index      = '0;
    logic [CFG_DATA_W-1:0]        i_cfg_data       = '0;
    logic                         o_in_stall;
    logic                         o_out_valid;
    logic signed [DRIVE_W-1:0]    o_drive;
    logic signed [16:0]           o_setpoint_now;
    logic                         o_cfg_ready;

    ramped_setpoint_pi_position_drive_core uut (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_in_valid       (i_in_valid),
        .o_in_stall       (o_in_stall),
        .i_measured_angle (i_measured_angle),
        .i_restart        (i_restart),
        .o_out_valid      (o_out_valid),
        .i_out_stall      (i_out_stall),
        .o_drive          (o_drive),
        .o_setpoint_now   (o_setpoint_now),
        .i_cfg_valid      (i_cfg_valid),
        .o_cfg_ready      (o_cfg_ready),
        .i_cfg_index      (i_cfg_index),
        .i_cfg_data       (i_cfg_data)
    );

    always #5 i_clk = ~i_clk;

    // predicted controller state and settings
    t_cfg               drv_cfg;
    logic signed [15:0] tgt_angle;
    logic signed [16:0] ramp_sp   = '0;
    logic [COUNT_W-1:0] tick_cnt  = '0;
    logic signed [17:0] err_hold  = '0;
    logic signed [31:0] err_acc   = '0;

    t_drive_result pending_drive[$];
    t_stim_row     directed_rows[$];

    int err_count     = 0;
    int results_seen  = 0;
    int ticks_sent    = 0;
    int cfg_writes    = 0;
    int cycle_cnt     = 0;
    int send_idle_pct = 0;
    int recv_stall_pct = 0;
    int hold_asked    = 0;
    int hold_served   = 0;
    int hold_left     = 0;

    always @(posedge i_clk) begin
        cycle_cnt <= cycle_cnt + 1;
        if (cycle_cnt == CYCLE_LIMIT) begin
            $display("Timeout after %0d cycles, %0d results outstanding",
                     cycle_cnt, pending_drive.size());
            $display("Testbench completed WITH ERRORS");
            $finish;
        end
    end

    // receiver stall, with an occasional long hold-off
    always @(posedge i_clk) begin
        if (hold_left != 0) begin
            i_out_stall <= 1'b1;
            hold_left   <= hold_left - 1;
        end else if (hold_served != hold_asked) begin
            i_out_stall <= 1'b1;
            hold_served <= hold_served + 1;
            hold_left   <= HOLD_CYCLES;
        end else begin
            i_out_stall <= ($urandom_range(99) < recv_stall_pct);
        end
    end

    always @(posedge i_clk) begin
        t_drive_result want;
        if (i_rst_n && o_out_valid === 1'b1 && i_out_stall == 1'b0) begin
            if (pending_drive.size() == 0) begin
                err_count++;
                if (err_count <= MAX_REPORTS)
                    $display("%0t: unexpected transfer, drive %0d setpoint %0d",
                             $time, o_drive, o_setpoint_now);
            end else begin
                want = pending_drive.pop_front();
                results_seen++;
                if (o_drive !== want.drive) begin
                    err_count++;
                    if (err_count <= MAX_REPORTS)
                        $display("%0t: drive mismatch, expected %0d, got %0d",
                                 $time, want.drive, o_drive);
                end
                if (o_setpoint_now !== want.setpoint) begin
                    err_count++;
                    if (err_count <= MAX_REPORTS)
                        $display("%0t: setpoint mismatch, expected %0d, got %0d",
                                 $time, want.setpoint, o_setpoint_now);
                end
            end
        end
    end

    function automatic logic signed [15:0] sat_angle(input longint v);
        if (v > longint'(ANGLE_MAX))
            return ANGLE_MAX;
        if (v < longint'(ANGLE_MIN))
            return ANGLE_MIN;
        return v[15:0];
    endfunction

    // random filler above each register's width; those bits are don't-care
    function automatic logic [CFG_DATA_W-1:0] cfg_word(input logic [CFG_IDX_W-1:0] idx,
                                                       input logic [CFG_DATA_W-1:0] val);
        logic [CFG_DATA_W-1:0] keep;
        case (idx)
            CFG_DIRECTION:                  keep = 24'h000001;
            CFG_TARGET_ANGLE, CFG_PROP_GAIN: keep = 24'h00FFFF;
            CFG_STEP_INTERVAL, CFG_STEP_SIZE: keep = 24'h0000FF;
            default:                        keep = 24'hFFFFFF;
        endcase
        return (val & keep) | (CFG_DATA_W'($urandom) & ~keep);
    endfunction

    function automatic t_stim_row cfg_row(input logic [CFG_IDX_W-1:0] idx,
                                          input logic [CFG_DATA_W-1:0] val);
        t_stim_row r;
        r      = '0;
        r.kind = ROW_CFG;
        r.idx  = idx;
        r.data = val;
        return r;
    endfunction

    function automatic t_stim_row tick_row(input logic signed [15:0] meas, input logic rbit,
                                           input int reps, input bit typed = 1'b0,
                                           input logic signed [DRIVE_W-1:0] drv = '0,
                                           input logic signed [16:0] sp = '0);
        t_stim_row r;
        r               = '0;
        r.kind          = ROW_TICK;
        r.meas          = meas;
        r.rbit          = rbit;
        r.reps          = reps;
        r.typed         = typed;
        r.want.drive    = drv;
        r.want.setpoint = sp;
        return r;
    endfunction

    task automatic compute_drive_tick(input logic signed [15:0] meas, input logic rbit,
                                      output t_drive_result res);
        logic   ramping;
        longint sum_wide;
        longint acc;
        longint quot;
        if (rbit)
            ramp_sp = meas;
        if (tick_cnt != COUNT_MAX)
            tick_cnt = tick_cnt + 1'b1;
        ramping = drv_cfg.direction ? (ramp_sp >= tgt_angle) : (ramp_sp <= tgt_angle);
        if (ramping) begin
            err_hold = ramp_sp - meas;
            if (tick_cnt >= drv_cfg.step_interval) begin
                if (drv_cfg.direction)
                    ramp_sp = ramp_sp - $signed({1'b0, drv_cfg.step_size});
                else
                    ramp_sp = ramp_sp + $signed({1'b0, drv_cfg.step_size});
                tick_cnt = '0;
            end
        end else begin
            ramp_sp = tgt_angle;
        end
        sum_wide = longint'(err_acc) + longint'(err_hold);
        if (sum_wide > SUM_MAX)
            sum_wide = SUM_MAX;
        else if (sum_wide < SUM_MIN)
            sum_wide = SUM_MIN;
        err_acc = sum_wide[31:0];
        acc = longint'(drv_cfg.prop_gain) * longint'(err_hold) * Q12_TO_Q24
            + longint'(drv_cfg.integ_gain) * longint'(err_acc);
        quot = acc / Q24_ONE;
        if (quot > DRIVE_LIMIT)
            quot = DRIVE_LIMIT;
        else if (quot < -DRIVE_LIMIT)
            quot = -DRIVE_LIMIT;
        res.drive    = quot[DRIVE_W-1:0];
        res.setpoint = ramp_sp;
    endtask

    task automatic send_tick(input logic signed [15:0] meas, input logic rbit,
                             input bit typed, input t_drive_result typed_res);
        t_drive_result res;
        while (send_idle_pct != 0 && $urandom_range(99) < send_idle_pct) begin
            i_in_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_in_valid       <= 1'b1;
        i_measured_angle <= meas;
        i_restart        <= rbit;
        @(posedge i_clk);
        while (o_in_stall !== 1'b0)
            @(posedge i_clk);
        compute_drive_tick(meas, rbit, res);
        pending_drive.push_back(typed ? typed_res : res);
        ticks_sent++;
    endtask

    task automatic drain();
        i_in_valid <= 1'b0;
        while (pending_drive.size() != 0)
            @(posedge i_clk);
        repeat (4) @(posedge i_clk);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] val);
        logic [CFG_DATA_W-1:0] word;
        word = cfg_word(idx, val);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= word;
        @(posedge i_clk);
        while (o_cfg_ready !== 1'b1)
            @(posedge i_clk);
        i_cfg_valid <= 1'b0;
        cfg_writes++;
        case (idx)
            CFG_DIRECTION:     drv_cfg.direction     = word[0];
            CFG_TARGET_ANGLE:  tgt_angle             = word[15:0];
            CFG_STEP_INTERVAL: drv_cfg.step_interval = word[7:0];
            CFG_STEP_SIZE:     drv_cfg.step_size     = word[7:0];
            CFG_PROP_GAIN:     drv_cfg.prop_gain     = word[15:0];
            CFG_INTEG_GAIN:    drv_cfg.integ_gain    = word[23:0];
            default: ;
        endcase
        @(posedge i_clk);
    endtask

    // one ramp: settings, usually a restart at a start angle, then ticks tracking the setpoint
    task automatic run_segment(input bit long_hold);
        logic signed [15:0]   start;
        logic signed [15:0]   tgt;
        logic                 dir;
        logic [7:0]           ivl;
        logic [7:0]           sz;
        logic [15:0]          kp;
        logic [23:0]          ki;
        longint               span;
        int                   len;
        int                   roll;
        t_drive_result        unused;
        unused = '0;
        drain();
        dir = 1'($urandom_range(1));
        case ($urandom_range(3))
            0:       ivl = 8'h00;
            1:       ivl = 8'hFF;
            default: ivl = 8'($urandom_range(1, 6));
        endcase
        case ($urandom_range(3))
            0:       sz = 8'h00;
            1:       sz = 8'hFF;
            default: sz = 8'($urandom_range(1, 254));
        endcase
        case ($urandom_range(3))
            0:       kp = 16'h0000;
            1:       kp = 16'hFFFF;
            2:       kp = PROP_GAIN_RST;
            default: kp = 16'($urandom);
        endcase
        case ($urandom_range(3))
            0:       ki = 24'h000000;
            1:       ki = 24'hFFFFFF;
            2:       ki = 24'($urandom_range(0, 4095));
            default: ki = 24'($urandom);
        endcase
        start = 16'($urandom);
        span  = longint'($urandom_range(4000));
        if ($urandom_range(5) == 0)
            tgt = 16'($urandom);
        else
            tgt = sat_angle(dir ? longint'(start) - span : longint'(start) + span);
        write_reg(CFG_DIRECTION, {23'd0, dir});
        write_reg(CFG_TARGET_ANGLE, {8'd0, tgt});
        write_reg(CFG_STEP_INTERVAL, {16'd0, ivl});
        write_reg(CFG_STEP_SIZE, {16'd0, sz});
        write_reg(CFG_PROP_GAIN, {8'd0, kp});
        write_reg(CFG_INTEG_GAIN, ki);
        if ($urandom_range(4) == 0)
            write_reg($urandom_range(1) ? CFG_IDX_SPARE1 : CFG_IDX_SPARE0, 24'($urandom));
        len = ($urandom_range(7) == 0) ? $urandom_range(260, 400) : $urandom_range(8, 48);
        if (long_hold)
            hold_asked <= hold_asked + 1;
        if ($urandom_range(5) != 0)
            send_tick(start, 1'b1, 1'b0, unused);
        for (int k = 0; k < len; k++) begin
            roll = $urandom_range(99);
            if (roll < 6)
                send_tick(16'($urandom), 1'($urandom_range(1)), 1'b0, unused);
            else if (roll < 9)
                send_tick(sat_angle(longint'(ramp_sp) + longint'($urandom_range(64)) - 32),
                          1'b1, 1'b0, unused);
            else
                send_tick(sat_angle(longint'(ramp_sp) + longint'($urandom_range(64)) - 32),
                          1'b0, 1'b0, unused);
        end
    endtask

    initial begin
        int directed_ticks;
        int cur_phase;
        int phase;
        bit first_seg;

        drv_cfg           = '0;
        drv_cfg.direction = DIRECTION_RST;
        drv_cfg.prop_gain = PROP_GAIN_RST;
        tgt_angle         = '0;

        // power-on values, extremes of the angle and restart
        directed_rows.push_back(tick_row(16'sd0, 1'b0, 1, 1'b1, 8'sd0, 17'sd0));
        directed_rows.push_back(tick_row(ANGLE_MIN, 1'b0, 1, 1'b1, 8'sd100, 17'sd0));
        directed_rows.push_back(tick_row(ANGLE_MAX, 1'b0, 1, 1'b1, -8'sd100, 17'sd0));
        directed_rows.push_back(tick_row(ANGLE_MAX, 1'b1, 1, 1'b1, 8'sd0, 17'sd32767));
        directed_rows.push_back(tick_row(ANGLE_MIN, 1'b1, 1, 1'b1, 8'sd0, 17'sd0));
        // zero interval: full step every tick, falling past target
        directed_rows.push_back(cfg_row(CFG_STEP_SIZE, 24'h0000FF));
        directed_rows.push_back(tick_row(16'sd1000, 1'b1, 1));
        directed_rows.push_back(tick_row(16'sd0, 1'b0, 6));
        // rising ramp, maximum proportional gain
        directed_rows.push_back(cfg_row(CFG_DIRECTION, 24'h000000));
        directed_rows.push_back(cfg_row(CFG_TARGET_ANGLE, 24'h007FFF));
        directed_rows.push_back(cfg_row(CFG_STEP_INTERVAL, 24'h000003));
        directed_rows.push_back(cfg_row(CFG_PROP_GAIN, 24'h00FFFF));
        directed_rows.push_back(cfg_row(CFG_INTEG_GAIN, 24'h001000));
        directed_rows.push_back(tick_row(ANGLE_MIN, 1'b1, 1));
        directed_rows.push_back(tick_row(-16'sd32700, 1'b0, 12));
        directed_rows.push_back(cfg_row(CFG_STEP_INTERVAL, 24'h0000FF));
        directed_rows.push_back(tick_row(-16'sd32700, 1'b0, 4));
        // zero step, integral only: build up with the largest error, then swing back negative
        directed_rows.push_back(cfg_row(CFG_STEP_SIZE, 24'h000000));
        directed_rows.push_back(cfg_row(CFG_DIRECTION, 24'h000001));
        directed_rows.push_back(cfg_row(CFG_TARGET_ANGLE, 24'h008000));
        directed_rows.push_back(cfg_row(CFG_PROP_GAIN, 24'h000000));
        directed_rows.push_back(cfg_row(CFG_INTEG_GAIN, 24'h000100));
        directed_rows.push_back(tick_row(ANGLE_MAX, 1'b1, 1));
        directed_rows.push_back(tick_row(ANGLE_MIN, 1'b0, 40));
        directed_rows.push_back(tick_row(ANGLE_MIN, 1'b1, 1));
        directed_rows.push_back(tick_row(ANGLE_MAX, 1'b0, 80));
        // unused register indexes must change nothing
        directed_rows.push_back(cfg_row(CFG_IDX_SPARE0, 24'hFFFFFF));
        directed_rows.push_back(cfg_row(CFG_IDX_SPARE1, 24'hFFFFFF));
        directed_rows.push_back(tick_row(16'sd5, 1'b0, 3));

        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;

        foreach (directed_rows[r]) begin
            if (directed_rows[r].kind == ROW_CFG) begin
                drain();
                write_reg(directed_rows[r].idx, directed_rows[r].data);
            end else begin
                repeat (directed_rows[r].reps)
                    send_tick(directed_rows[r].meas, directed_rows[r].rbit,
                              directed_rows[r].typed, directed_rows[r].want);
            end
        end
        directed_ticks = ticks_sent;

        cur_phase = -1;
        first_seg = 1'b0;
        while (ticks_sent - directed_ticks < RAND_TICKS) begin
            phase = (ticks_sent - directed_ticks) * 3 / RAND_TICKS;
            if (phase != cur_phase) begin
                cur_phase = phase;
                first_seg = 1'b1;
                case (phase)
                    0: begin
                        send_idle_pct  = 16;
                        recv_stall_pct <= 53;
                    end
                    1: begin
                        send_idle_pct  = 53;
                        recv_stall_pct <= 16;
                    end
                    default: begin
                        send_idle_pct  = 0;
                        recv_stall_pct <= 0;
                    end
                endcase
            end
            run_segment(first_seg);
            first_seg = 1'b0;
        end

        drain();
        $display("Ran %0d ticks (%0d directed, %0d random), %0d register writes, %0d checked.",
                 ticks_sent, directed_ticks, ticks_sent - directed_ticks, cfg_writes,
                 results_seen);
        $display("Both ramp directions, restarts, held error and integral build-up both ways.");
        if (err_count == 0)
            $display("Testbench completed without errors");
        else
            $display("Testbench completed WITH ERRORS");
        $finish;
    end

endmodule

>>> sim.f
+incdir+rtl/core
rtl/core/rspd_pkg.sv
rtl/core/rspd_cfg.sv
rtl/core/rspd_ramp.sv
rtl/core/rspd_drive.sv
rtl/core/ramped_setpoint_pi_position_drive_core.sv
bench/tb_ramped_setpoint_pi_position_drive_core.sv
